[sv/cbl_pkg.sv]
// Shared constants for the charge-based LRU cache core.
// Operation and status codes, default sizes and field widths.
// No dependencies.
package cbl_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int CHARGE_W = 16;
    localparam int HANDLE_W = 4;
    localparam int USAGE_W  = 20;
    localparam int EVICT_W  = 5;
    localparam int REF_W    = 8;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;
    localparam logic [1:0] FUNC_ERASE   = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EXISTING   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [2:0] ST_NO_FREE    = 3'd3;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd4;

    localparam logic [REF_W-1:0]   REF_MAX   = 8'd255;
    localparam logic [USAGE_W-1:0] USAGE_MAX = 20'hFFFFF;
    localparam logic [EVICT_W-1:0] EVICT_MAX = 5'd31;

endpackage

[sv/cbl_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// Read returns old data on a same-address write. No dependencies.
module cbl_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] wa,
    input  logic [W-1:0]         wd,
    input  logic [$clog2(D)-1:0] ra,
    output logic [W-1:0]         rd
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end
endmodule

[sv/charge_based_lru_cache_core.sv]
// Charge-based LRU cache core: control sequencer around entry RAMs.
// Depends on cbl_pkg and cbl_ram.
//
// Use:
//   Requests enter on the s_ stream (s_tuser = func; s_tdata = key, value,
//   charge, slot). One result per request leaves on the m_ stream
//   (m_tuser = status; m_tdata = handle, read_value, usage, evicted_count).
//   capacity_limit is written through cfg_wr_en / cfg_wr_data, only while idle; the core does not enforce this.
// Timing:
//   One request at a time. Release skips the key scan. Lookup, erase
//   and insert scan every slot's key RAM entry, one per cycle; an insert
//   over capacity_limit first walks the eviction list from the oldest
//   entry.
// Reset:
//   aresetn low empties the cache, clears usage and capacity_limit and the
//   output valid flag. No clearing pass is needed.
// Stall:
//   A finished result waits in the output register; the core takes the next
//   request meanwhile and holds its own result until the register frees.
module charge_based_lru_cache_core #(
    parameter int SLOTS      = cbl_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = cbl_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = cbl_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [19:0] cfg_wr_data,  // capacity_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,      // key[31:0] value[63:32] charge[79:64] slot[83:80]
    input  logic [1:0]  s_tuser,      // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,      // handle[3:0] read_value[35:4] usage[55:36] evicted[60:56]
    output logic [2:0]  m_tuser       // status[2:0]
);
    import cbl_pkg::*;

    localparam int IW  = $clog2(SLOTS);
    localparam int UW  = IW + CHARGE_W + 1;
    localparam int CW  = (UW > USAGE_W + 1) ? UW : USAGE_W + 1;
    localparam int KVW = KEY_BITS + VALUE_BITS;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EV_RD    = 4'd1;
    localparam logic [3:0] S_EV_CHK   = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_SCAN_END = 4'd4;
    localparam logic [3:0] S_DECIDE   = 4'd5;
    localparam logic [3:0] S_ACT      = 4'd6;
    localparam logic [3:0] S_ACT2     = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic [SLOTS-1:0]      tab_reg, tab_next;
    logic [IW-1:0]         oldest_reg, oldest_next;
    logic [IW-1:0]         newest_reg, newest_next;
    logic                  empty_reg, empty_next;
    logic [UW-1:0]         usage_reg, usage_next;
    logic [USAGE_W-1:0]    cap_reg;
    logic [1:0]            op_func_reg, op_func_next;
    logic [KEY_BITS-1:0]   op_key_reg, op_key_next;
    logic [VALUE_BITS-1:0] op_val_reg, op_val_next;
    logic [CHARGE_W-1:0]   op_chg_reg, op_chg_next;
    logic [HANDLE_W-1:0]   op_slot_reg, op_slot_next;
    logic [IW-1:0]         h_reg, h_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic [IW-1:0]         pidx_reg, pidx_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         fslot_reg, fslot_next;
    logic                  free_reg, free_next;
    logic [IW-1:0]         free_slot_reg, free_slot_next;
    logic [EVICT_W-1:0]    evict_reg, evict_next;
    logic [2:0]            res_st_reg, res_st_next;
    logic [HANDLE_W-1:0]   res_h_reg, res_h_next;
    logic [VALUE_W-1:0]    res_v_reg, res_v_next;
    logic                  m_valid_reg, m_valid_next;
    logic [63:0]           m_data_reg, m_data_next;
    logic [2:0]            m_user_reg, m_user_next;

    logic [IW-1:0]       rd_addr;
    logic [KVW-1:0]      kv_q;
    logic [CHARGE_W-1:0] chg_q;
    logic [REF_W-1:0]    ref_q;
    logic [IW-1:0]       newer_q, older_q;
    logic                ins_we;
    logic [IW-1:0]       ins_wa;
    logic                ref_we;
    logic [IW-1:0]       ref_wa;
    logic [REF_W-1:0]    ref_wd;
    logic                nw_we, ol_we;
    logic [IW-1:0]       nw_wa, nw_wd, ol_wa, ol_wd;

    logic                unl_en;
    logic [IW-1:0]       unl_s, unl_o, unl_n;
    logic [CW-1:0]       need;
    logic [UW-1:0]       usage_after;
    logic [IW-1:0]       sidx;
    logic                slot_ok;
    logic                rel_ok;
    logic [REF_W-1:0]    ref_dec;
    logic [KEY_BITS-1:0] in_key;
    logic [CHARGE_W-1:0] in_chg;
    logic [USAGE_W-1:0]  usage_sat;

    cbl_ram #(.W(KVW), .D(SLOTS)) u_kv (
        .clk(aclk), .we(ins_we), .wa(ins_wa), .wd({op_key_reg, op_val_reg}),
        .ra(rd_addr), .rd(kv_q));
    cbl_ram #(.W(CHARGE_W), .D(SLOTS)) u_chg (
        .clk(aclk), .we(ins_we), .wa(ins_wa), .wd(op_chg_reg),
        .ra(rd_addr), .rd(chg_q));
    cbl_ram #(.W(REF_W), .D(SLOTS)) u_ref (
        .clk(aclk), .we(ref_we), .wa(ref_wa), .wd(ref_wd),
        .ra(rd_addr), .rd(ref_q));
    cbl_ram #(.W(IW), .D(SLOTS)) u_newer (
        .clk(aclk), .we(nw_we), .wa(nw_wa), .wd(nw_wd),
        .ra(rd_addr), .rd(newer_q));
    cbl_ram #(.W(IW), .D(SLOTS)) u_older (
        .clk(aclk), .we(ol_we), .wa(ol_wa), .wd(ol_wd),
        .ra(rd_addr), .rd(older_q));

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign in_key    = KEY_BITS'(s_tdata[31:0]);
    assign in_chg    = s_tdata[79:64];
    assign sidx      = IW'(op_slot_reg);
    assign slot_ok   = (32'(op_slot_reg) < SLOTS);
    assign ref_dec   = ref_q - 1'b1;
    assign usage_sat = (usage_reg > UW'(USAGE_MAX)) ? USAGE_MAX : USAGE_W'(usage_reg);

    always_comb begin
        unique case (state_reg)
            S_SCAN:   rd_addr = idx_reg;
            S_DECIDE: rd_addr = (op_func_reg == FUNC_RELEASE) ? sidx : fslot_reg;
            default:  rd_addr = h_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        tab_next       = tab_reg;
        oldest_next    = oldest_reg;
        newest_next    = newest_reg;
        empty_next     = empty_reg;
        usage_next     = usage_reg;
        op_func_next   = op_func_reg;
        op_key_next    = op_key_reg;
        op_val_next    = op_val_reg;
        op_chg_next    = op_chg_reg;
        op_slot_next   = op_slot_reg;
        h_next         = h_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pidx_next      = pidx_reg;
        found_next     = found_reg;
        fslot_next     = fslot_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        evict_next     = evict_reg;
        res_st_next    = res_st_reg;
        res_h_next     = res_h_reg;
        res_v_next     = res_v_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        ins_we = 1'b0;
        ins_wa = free_slot_reg;
        ref_we = 1'b0;
        ref_wa = fslot_reg;
        ref_wd = ref_q;
        nw_we  = 1'b0;
        nw_wa  = newest_reg;
        nw_wd  = fslot_reg;
        ol_we  = 1'b0;
        ol_wa  = fslot_reg;
        ol_wd  = newest_reg;
        unl_en = 1'b0;
        unl_s  = fslot_reg;
        unl_o  = older_q;
        unl_n  = newer_q;
        need        = CW'(usage_reg) + CW'(in_chg);
        usage_after = usage_reg;
        rel_ok      = 1'b0;

        // key compare and free-slot search, one RAM entry behind the scan address
        if (pend_reg) begin
            if (valid_reg[pidx_reg] && tab_reg[pidx_reg] && !found_reg
                    && kv_q[KVW-1:VALUE_BITS] == op_key_reg) begin
                found_next = 1'b1;
                fslot_next = pidx_reg;
            end
            if (!valid_reg[pidx_reg] && !free_reg) begin
                free_next      = 1'b1;
                free_slot_next = pidx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_func_next = s_tuser;
                    op_key_next  = in_key;
                    op_val_next  = VALUE_BITS'(s_tdata[63:32]);
                    op_chg_next  = in_chg;
                    op_slot_next = s_tdata[83:80];
                    evict_next   = '0;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    free_next    = 1'b0;
                    h_next       = oldest_reg;
                    if (s_tuser == FUNC_RELEASE) begin
                        state_next = S_DECIDE;
                    end else if (s_tuser == FUNC_INSERT && !empty_reg
                            && need > CW'(cap_reg)) begin
                        state_next = S_EV_RD;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_EV_RD: begin
                state_next = S_EV_CHK;
            end
            S_EV_CHK: begin
                if (ref_q == '0) begin
                    unl_en = 1'b1;
                    unl_s  = h_reg;
                    usage_after = usage_reg - UW'(chg_q);
                    valid_next[h_reg] = 1'b0;
                    tab_next[h_reg]   = 1'b0;
                    if (evict_reg != EVICT_MAX) begin
                        evict_next = evict_reg + 1'b1;
                    end
                end
                usage_next = usage_after;
                h_next     = newer_q;
                need       = CW'(usage_after) + CW'(op_chg_reg);
                if (h_reg != newest_reg && need > CW'(cap_reg)) begin
                    state_next = S_EV_RD;
                end else begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                pend_next = 1'b1;
                pidx_next = idx_reg;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LAST) begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                pend_next  = 1'b0;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                state_next = S_ACT;
            end
            S_ACT: begin
                state_next = S_FIN;
                res_st_next = ST_OK;
                res_h_next  = '0;
                res_v_next  = '0;
                case (op_func_reg)
                    FUNC_INSERT: begin
                        if (found_reg) begin
                            ref_we = 1'b1;
                            ref_wd = (ref_q == REF_MAX) ? ref_q : ref_q + 1'b1;
                            res_st_next = ST_EXISTING;
                            res_h_next  = HANDLE_W'(fslot_reg);
                            res_v_next  = VALUE_W'(kv_q[VALUE_BITS-1:0]);
                        end else if (!free_reg) begin
                            res_st_next = ST_NO_FREE;
                        end else begin
                            ins_we = 1'b1;
                            ref_we = 1'b1;
                            ref_wa = free_slot_reg;
                            ref_wd = REF_W'(1);
                            valid_next[free_slot_reg] = 1'b1;
                            tab_next[free_slot_reg]   = 1'b1;
                            if (empty_reg) begin
                                oldest_next = free_slot_reg;
                                empty_next  = 1'b0;
                            end else begin
                                ol_we = 1'b1;
                                ol_wa = free_slot_reg;
                                nw_we = 1'b1;
                                nw_wd = free_slot_reg;
                            end
                            newest_next = free_slot_reg;
                            usage_next  = usage_reg + UW'(op_chg_reg);
                            res_h_next  = HANDLE_W'(free_slot_reg);
                            res_v_next  = VALUE_W'(op_val_reg);
                        end
                    end
                    FUNC_LOOKUP: begin
                        if (found_reg) begin
                            unl_en = 1'b1;
                            ref_we = 1'b1;
                            ref_wd = (ref_q == REF_MAX) ? ref_q : ref_q + 1'b1;
                            res_h_next = HANDLE_W'(fslot_reg);
                            res_v_next = VALUE_W'(kv_q[VALUE_BITS-1:0]);
                            state_next = S_ACT2;
                        end else begin
                            res_st_next = ST_NOT_FOUND;
                        end
                    end
                    FUNC_RELEASE: begin
                        res_h_next = op_slot_reg;
                        rel_ok = slot_ok && valid_reg[sidx] && (ref_q != '0);
                        if (rel_ok) begin
                            ref_we = 1'b1;
                            ref_wa = sidx;
                            ref_wd = ref_dec;
                            if (ref_dec == '0 && !tab_reg[sidx]) begin
                                unl_en = 1'b1;
                                unl_s  = sidx;
                                usage_next = usage_reg - UW'(chg_q);
                                valid_next[sidx] = 1'b0;
                            end
                        end else begin
                            res_st_next = ST_BAD_HANDLE;
                        end
                    end
                    default: begin
                        if (found_reg) begin
                            res_h_next = HANDLE_W'(fslot_reg);
                            tab_next[fslot_reg] = 1'b0;
                            if (ref_q == '0) begin
                                unl_en = 1'b1;
                                usage_next = usage_reg - UW'(chg_q);
                                valid_next[fslot_reg] = 1'b0;
                            end
                        end else begin
                            res_st_next = ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            S_ACT2: begin
                state_next = S_FIN;
                if (empty_reg) begin
                    oldest_next = fslot_reg;
                    empty_next  = 1'b0;
                end else begin
                    ol_we = 1'b1;
                    nw_we = 1'b1;
                end
                newest_next = fslot_reg;
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_st_reg;
                    m_data_next  = {3'b000, evict_reg, usage_sat, res_v_reg, res_h_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // unlink from the recency list
        if (unl_en) begin
            if (unl_s == oldest_reg && unl_s == newest_reg) begin
                empty_next = 1'b1;
            end else if (unl_s == oldest_reg) begin
                oldest_next = unl_n;
            end else if (unl_s == newest_reg) begin
                newest_next = unl_o;
            end else begin
                nw_we = 1'b1;
                nw_wa = unl_o;
                nw_wd = unl_n;
                ol_we = 1'b1;
                ol_wa = unl_n;
                ol_wd = unl_o;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            tab_reg     <= '0;
            oldest_reg  <= '0;
            newest_reg  <= '0;
            empty_reg   <= 1'b1;
            usage_reg   <= '0;
            cap_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            evict_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            tab_reg     <= tab_next;
            oldest_reg  <= oldest_next;
            newest_reg  <= newest_next;
            empty_reg   <= empty_next;
            usage_reg   <= usage_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            free_reg    <= free_next;
            evict_reg   <= evict_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_func_reg   <= op_func_next;
        op_key_reg    <= op_key_next;
        op_val_reg    <= op_val_next;
        op_chg_reg    <= op_chg_next;
        op_slot_reg   <= op_slot_next;
        h_reg         <= h_next;
        idx_reg       <= idx_next;
        pidx_reg      <= pidx_next;
        fslot_reg     <= fslot_next;
        free_slot_reg <= free_slot_next;
        res_st_reg    <= res_st_next;
        res_h_reg     <= res_h_next;
        res_v_reg     <= res_v_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end
endmodule

[sv/cbl_checker.sv]
// Port-level checks for charge_based_lru_cache_core, bound to the top level.
// Depends on cbl_pkg.
module cbl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import cbl_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request in flight
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_BAD_HANDLE)
        else $error("status out of range");

    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_NOT_FOUND || m_tuser == ST_NO_FREE)
        |-> m_tdata[35:0] == 36'd0)
        else $error("miss carries handle or value");
endmodule

bind charge_based_lru_cache_core cbl_checker u_cbl_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
